@@ rtl/bcct_pkg.sv @@
// Shared types and constants for the box and circle collision test block.
package bcct_pkg;

  localparam int REQ_W = 2;
  localparam int WORD_W = 32;
  localparam int RAD_W = 16;

  typedef enum logic [REQ_W-1:0] {
    REQ_BOX_BOX       = 2'd0,
    REQ_CIRCLE_CIRCLE = 2'd1,
    REQ_BOX_CIRCLE    = 2'd2,
    REQ_CIRCLE_BOX    = 2'd3
  } req_kind_t;

endpackage

@@ rtl/box_circle_collision_test.sv @@
// Pipelined pairwise 2D box and circle collision test, one pair per cycle while in_stall is low.
//
//  channel | direction | handshake          | beat fields
//  --------+-----------+--------------------+---------------------------------------------
//  in      | into      | in_valid, in_stall | req_type, a_lo, a_hi, a_pos, a_radius,
//          |           |                    | b_lo, b_hi, b_pos, b_radius
//  out     | out of    | out_valid,out_stall| hit
//
// A beat passes five register stages: s1, s2, s3, s4 and the output register.
// A new beat is taken every cycle while in_stall is low, and the squaring stage
// sets the cycle time.
// Reset clears only the stage valid bits; the data registers hold no state.
// A stall on the output freezes every full stage; empty stages still fill,
// so bubbles are squeezed out and in_stall rises only when the pipe is full.
module box_circle_collision_test #(
  parameter int COORD_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [bcct_pkg::REQ_W-1:0]       req_type,
  input  logic [bcct_pkg::WORD_W-1:0]      a_lo,
  input  logic [bcct_pkg::WORD_W-1:0]      a_hi,
  input  logic [bcct_pkg::WORD_W-1:0]      a_pos,
  input  logic [bcct_pkg::RAD_W-1:0]       a_radius,
  input  logic [bcct_pkg::WORD_W-1:0]      b_lo,
  input  logic [bcct_pkg::WORD_W-1:0]      b_hi,
  input  logic [bcct_pkg::WORD_W-1:0]      b_pos,
  input  logic [bcct_pkg::RAD_W-1:0]       b_radius,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             hit
);
  import bcct_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int CW = COORD_BITS + 1;
  localparam int PW = 2 * CW;

  // Handshake chain: a stage may load when it is empty or its successor moves.
  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  logic s1_valid, s2_valid, s3_valid, s4_valid;

  assign rdy5     = !out_valid || !out_stall;
  assign rdy4     = !s4_valid || rdy5;
  assign rdy3     = !s3_valid || rdy4;
  assign rdy2     = !s2_valid || rdy3;
  assign rdy1     = !s1_valid || rdy2;
  assign in_stall = !rdy1;

  // ---------------- stage 1: unpack and translate the boxes ----------------
  logic [2*WORD_W-1:0] alo_w, ahi_w, apos_w, blo_w, bhi_w, bpos_w;
  logic [WORD_W-1:0]   arad_w, brad_w;
  logic signed [C-1:0] alx, aly, ahx, ahy, apx, apy;
  logic signed [C-1:0] blx, bly, bhx, bhy, bpx, bpy;

  assign alo_w  = {{WORD_W{1'b0}}, a_lo};
  assign ahi_w  = {{WORD_W{1'b0}}, a_hi};
  assign apos_w = {{WORD_W{1'b0}}, a_pos};
  assign blo_w  = {{WORD_W{1'b0}}, b_lo};
  assign bhi_w  = {{WORD_W{1'b0}}, b_hi};
  assign bpos_w = {{WORD_W{1'b0}}, b_pos};
  assign arad_w = {{(WORD_W-RAD_W){1'b0}}, a_radius};
  assign brad_w = {{(WORD_W-RAD_W){1'b0}}, b_radius};

  assign alx = alo_w[0 +: C];
  assign aly = alo_w[C +: C];
  assign ahx = ahi_w[0 +: C];
  assign ahy = ahi_w[C +: C];
  assign apx = apos_w[0 +: C];
  assign apy = apos_w[C +: C];
  assign blx = blo_w[0 +: C];
  assign bly = blo_w[C +: C];
  assign bhx = bhi_w[0 +: C];
  assign bhy = bhi_w[C +: C];
  assign bpx = bpos_w[0 +: C];
  assign bpy = bpos_w[C +: C];

  req_kind_t            s1_kind;
  logic signed [CW-1:0] s1_ax1, s1_ay1, s1_ax2, s1_ay2;
  logic signed [CW-1:0] s1_bx1, s1_by1, s1_bx2, s1_by2;
  logic signed [C-1:0]  s1_apx, s1_apy, s1_bpx, s1_bpy;
  logic [C-1:0]         s1_ra, s1_rb;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rdy1) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_kind <= req_kind_t'(req_type);
      s1_ax1  <= {alx[C-1], alx} + {apx[C-1], apx};
      s1_ay1  <= {aly[C-1], aly} + {apy[C-1], apy};
      s1_ax2  <= {ahx[C-1], ahx} + {apx[C-1], apx};
      s1_ay2  <= {ahy[C-1], ahy} + {apy[C-1], apy};
      s1_bx1  <= {blx[C-1], blx} + {bpx[C-1], bpx};
      s1_by1  <= {bly[C-1], bly} + {bpy[C-1], bpy};
      s1_bx2  <= {bhx[C-1], bhx} + {bpx[C-1], bpx};
      s1_by2  <= {bhy[C-1], bhy} + {bpy[C-1], bpy};
      s1_apx  <= apx;
      s1_apy  <= apy;
      s1_bpx  <= bpx;
      s1_bpy  <= bpy;
      s1_ra   <= arad_w[C-1:0];
      s1_rb   <= brad_w[C-1:0];
    end
  end

  // ------- stage 2: box overlap, pick box and circle, clamp the centre -------
  logic                 box_is_b;
  logic signed [CW-1:0] sx1, sy1, sx2, sy2, scx, scy, tx, ty, clx, cly;
  logic [C-1:0]         sr;
  logic                 bb_hit_c, inside_c;

  always_comb begin
    bb_hit_c = (s1_ax1 < s1_bx2) && (s1_ay1 < s1_by2) &&
               (s1_bx1 < s1_ax2) && (s1_by1 < s1_ay2);
    box_is_b = (s1_kind == REQ_CIRCLE_BOX);
    sx1 = box_is_b ? s1_bx1 : s1_ax1;
    sy1 = box_is_b ? s1_by1 : s1_ay1;
    sx2 = box_is_b ? s1_bx2 : s1_ax2;
    sy2 = box_is_b ? s1_by2 : s1_ay2;
    scx = box_is_b ? {s1_apx[C-1], s1_apx} : {s1_bpx[C-1], s1_bpx};
    scy = box_is_b ? {s1_apy[C-1], s1_apy} : {s1_bpy[C-1], s1_bpy};
    sr  = box_is_b ? s1_ra : s1_rb;
    inside_c = (sx1 <= scx) && (scx <= sx2) && (sy1 <= scy) && (scy <= sy2);
    // Clamp to the upper edge first, then the lower, so a box with lo above
    // hi clamps to its lower edge.
    tx  = (scx < sx2) ? scx : sx2;
    ty  = (scy < sy2) ? scy : sy2;
    clx = (tx > sx1) ? tx : sx1;
    cly = (ty > sy1) ? ty : sy1;
  end

  req_kind_t            s2_kind;
  logic                 s2_bb_hit, s2_inside;
  logic signed [CW-1:0] s2_cx, s2_cy, s2_px, s2_py, s2_dx, s2_dy;
  logic [CW-1:0]        s2_r, s2_rs;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (rdy2) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_kind   <= s1_kind;
      s2_bb_hit <= bb_hit_c;
      s2_inside <= inside_c;
      s2_cx     <= scx;
      s2_cy     <= scy;
      s2_px     <= clx;
      s2_py     <= cly;
      s2_dx     <= {s1_apx[C-1], s1_apx} - {s1_bpx[C-1], s1_bpx};
      s2_dy     <= {s1_apy[C-1], s1_apy} - {s1_bpy[C-1], s1_bpy};
      s2_r      <= {1'b0, sr};
      s2_rs     <= {1'b0, s1_ra} + {1'b0, s1_rb};
    end
  end

  // -------- stage 3: offsets and their magnitudes, pick squaring operands --------
  logic signed [CW:0]   ex, ey, ex_neg, ey_neg;
  logic signed [CW-1:0] dx_neg, dy_neg;
  logic [CW-1:0]        mex, mey, mdx, mdy;

  always_comb begin
    ex     = {s2_cx[CW-1], s2_cx} - {s2_px[CW-1], s2_px};
    ey     = {s2_cy[CW-1], s2_cy} - {s2_py[CW-1], s2_py};
    ex_neg = -ex;
    ey_neg = -ey;
    dx_neg = -s2_dx;
    dy_neg = -s2_dy;
    // Each magnitude stays below 2^(COORD_BITS+1), so the top bit is dropped.
    mex = ex[CW] ? ex_neg[CW-1:0] : ex[CW-1:0];
    mey = ey[CW] ? ey_neg[CW-1:0] : ey[CW-1:0];
    mdx = s2_dx[CW-1] ? dx_neg : s2_dx;
    mdy = s2_dy[CW-1] ? dy_neg : s2_dy;
  end

  req_kind_t     s3_kind;
  logic          s3_bb_hit, s3_inside;
  logic [CW-1:0] s3_mx, s3_my, s3_mr;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (rdy3) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_kind   <= s2_kind;
      s3_bb_hit <= s2_bb_hit;
      s3_inside <= s2_inside;
      s3_mx     <= (s2_kind == REQ_CIRCLE_CIRCLE) ? mdx : mex;
      s3_my     <= (s2_kind == REQ_CIRCLE_CIRCLE) ? mdy : mey;
      s3_mr     <= (s2_kind == REQ_CIRCLE_CIRCLE) ? s2_rs : s2_r;
    end
  end

  // ---------------- stage 4: three squares ----------------
  req_kind_t     s4_kind;
  logic          s4_bb_hit, s4_inside;
  logic [PW-1:0] s4_sqx, s4_sqy, s4_sqr;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (rdy4) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      s4_kind   <= s3_kind;
      s4_bb_hit <= s3_bb_hit;
      s4_inside <= s3_inside;
      s4_sqx    <= PW'(s3_mx) * PW'(s3_mx);
      s4_sqy    <= PW'(s3_my) * PW'(s3_my);
      s4_sqr    <= PW'(s3_mr) * PW'(s3_mr);
    end
  end

  // ---------------- stage 5: sum, compare, output register ----------------
  logic [PW:0] dist_sq;
  logic        near_c, hit_next;

  always_comb begin
    dist_sq = {1'b0, s4_sqx} + {1'b0, s4_sqy};
    near_c  = dist_sq <= {1'b0, s4_sqr};
    case (s4_kind)
      REQ_BOX_BOX:       hit_next = s4_bb_hit;
      REQ_CIRCLE_CIRCLE: hit_next = near_c;
      default:           hit_next = s4_inside || near_c;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy5) begin
      out_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      hit <= hit_next;
    end
  end

  // ---------------- checks ----------------
  a_accept_fills_first_stage: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> s1_valid)
    else $error("accepted beat did not reach the first stage");

  a_inside_clamp_is_centre: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && s2_inside) |-> (s2_px == s2_cx && s2_py == s2_cy))
    else $error("centre inside the box but clamped point differs");

  a_full_pipe_stalls_input: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s2_valid && s3_valid && s4_valid && out_valid && out_stall)
    |-> in_stall)
    else $error("input not stalled while every stage is held");

endmodule
